[hdl/acr_pkg.sv]
`timescale 1ns / 1ps

package acr_pkg;

	localparam int SAMPLE_W         = 64;
	localparam int CHAN_W           = 3;
	localparam int COUNT_W          = 4;
	localparam int ROUTE_W          = 24;
	localparam int STORE_DEPTH      = 8;
	localparam int PAIR_SLOTS       = 8;
	localparam int DEF_MAX_CHANNELS = 8;
	localparam int APB_ADDR_W       = 5;
	localparam int APB_DATA_W       = 32;

	// Register indexes, taken from byte address bits [4:2].
	localparam logic [2:0] REG_IN_CHANNELS  = 3'd0;
	localparam logic [2:0] REG_OUT_CHANNELS = 3'd1;
	localparam logic [2:0] REG_EXPLICIT     = 3'd2;
	localparam logic [2:0] REG_ROUTE_COUNT  = 3'd3;
	localparam logic [2:0] REG_ROUTE_SRC    = 3'd4;
	localparam logic [2:0] REG_ROUTE_TGT    = 3'd5;
	localparam logic [2:0] REG_BPS          = 3'd6;

	// Register reset values.
	localparam logic [COUNT_W-1:0] RST_IN_CHANNELS  = 4'd2;
	localparam logic [COUNT_W-1:0] RST_OUT_CHANNELS = 4'd2;
	localparam logic [COUNT_W-1:0] RST_BPS          = 4'd2;

	typedef struct packed {
		logic [COUNT_W-1:0] in_channels;
		logic [COUNT_W-1:0] out_channels;
		logic               explicit_routing;
		logic [COUNT_W-1:0] route_count;
		logic [ROUTE_W-1:0] route_sources;
		logic [ROUTE_W-1:0] route_targets;
		logic [COUNT_W-1:0] bytes_per_sample;
	} cfg_t;

	typedef struct packed {
		logic [CHAN_W-1:0] src;
		logic [CHAN_W-1:0] tgt;
		logic              bad;
	} route_t;

	// A channel count of zero behaves as one; anything above the limit is clamped.
	function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] v,
			input logic [COUNT_W-1:0] lim);
		logic [COUNT_W-1:0] r;
		if (v == '0) begin
			r = COUNT_W'(1);
		end else if (v > lim) begin
			r = lim;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic bps_ok(input logic [COUNT_W-1:0] bps);
		logic r;
		case (bps)
			4'd1, 4'd2, 4'd3, 4'd4, 4'd8: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [SAMPLE_W-1:0] bps_mask(input logic [COUNT_W-1:0] bps);
		logic [SAMPLE_W-1:0] r;
		case (bps)
			4'd1:    r = 64'h0000_0000_0000_00FF;
			4'd2:    r = 64'h0000_0000_0000_FFFF;
			4'd3:    r = 64'h0000_0000_00FF_FFFF;
			4'd4:    r = 64'h0000_0000_FFFF_FFFF;
			4'd8:    r = 64'hFFFF_FFFF_FFFF_FFFF;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[hdl/acr_ram.sv]
`timescale 1ns / 1ps

module acr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/acr_regs.sv]
`timescale 1ns / 1ps

module acr_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [acr_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [acr_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [acr_pkg::APB_DATA_W-1:0]   prdata,
	output acr_pkg::cfg_t                    cfg
);

	import acr_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_channels      <= RST_IN_CHANNELS;
			cfg_q.out_channels     <= RST_OUT_CHANNELS;
			cfg_q.explicit_routing <= 1'b0;
			cfg_q.route_count      <= '0;
			cfg_q.route_sources    <= '0;
			cfg_q.route_targets    <= '0;
			cfg_q.bytes_per_sample <= RST_BPS;
		end else if (wr_en) begin
			case (reg_idx)
				REG_IN_CHANNELS:  cfg_q.in_channels      <= pwdata[COUNT_W-1:0];
				REG_OUT_CHANNELS: cfg_q.out_channels     <= pwdata[COUNT_W-1:0];
				REG_EXPLICIT:     cfg_q.explicit_routing <= pwdata[0];
				REG_ROUTE_COUNT:  cfg_q.route_count      <= pwdata[COUNT_W-1:0];
				REG_ROUTE_SRC:    cfg_q.route_sources    <= pwdata[ROUTE_W-1:0];
				REG_ROUTE_TGT:    cfg_q.route_targets    <= pwdata[ROUTE_W-1:0];
				REG_BPS:          cfg_q.bytes_per_sample <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_IN_CHANNELS:  prdata = APB_DATA_W'(cfg_q.in_channels);
			REG_OUT_CHANNELS: prdata = APB_DATA_W'(cfg_q.out_channels);
			REG_EXPLICIT:     prdata = APB_DATA_W'(cfg_q.explicit_routing);
			REG_ROUTE_COUNT:  prdata = APB_DATA_W'(cfg_q.route_count);
			REG_ROUTE_SRC:    prdata = APB_DATA_W'(cfg_q.route_sources);
			REG_ROUTE_TGT:    prdata = APB_DATA_W'(cfg_q.route_targets);
			REG_BPS:          prdata = APB_DATA_W'(cfg_q.bytes_per_sample);
			default:          prdata = '0;
		endcase
	end

endmodule

[hdl/acr_route.sv]
`timescale 1ns / 1ps

module acr_route (
	input  acr_pkg::cfg_t                     cfg,
	input  logic [acr_pkg::COUNT_W-1:0]       nin,
	input  logic [acr_pkg::COUNT_W-1:0]       nout,
	input  logic [acr_pkg::CHAN_W-1:0]        pair_idx,
	output acr_pkg::route_t                   route
);

	import acr_pkg::*;

	logic [4:0] bit_pos;

	// Each pair occupies three bits of the packed source and target registers.
	assign bit_pos = 5'(pair_idx) * 5'd3;

	always_comb begin
		if (cfg.explicit_routing) begin
			route.src = cfg.route_sources[bit_pos +: CHAN_W];
			route.tgt = cfg.route_targets[bit_pos +: CHAN_W];
		end else if (nin == COUNT_W'(1)) begin
			route.src = '0;
			route.tgt = pair_idx;
		end else begin
			route.src = pair_idx;
			route.tgt = pair_idx;
		end
		route.bad = ({1'b0, route.src} >= nin) || ({1'b0, route.tgt} >= nout);
	end

endmodule

[hdl/audio_channel_router.sv]
`timescale 1ns / 1ps

// Audio channel router.
// Interleaved samples arrive one channel per request on the input channel
// (sample_in, in_valid, in_ready) and are written into a small frame store.
// Requests are taken whenever the block is idle (in_ready high). The
// last channel starts a route pass that walks the route pairs once through a
// shared compare unit, one pair per cycle (route_count pairs in explicit
// mode, at most two or min(in, out) pairs in default mode, no pairs when
// the count is out of range). After that each output channel goes through
// a frame store read, a load of the output register, and a handover
// on the output channel (sample_out, out_channel, frame_end, out_valid,
// out_ready). in_ready stays low from the last input request until the
// last output of the frame has been taken. If the receiver stalls, the
// output register simply holds its result and the sequencer waits; nothing
// is lost or repeated. Reset clears the channel position and loads the
// register defaults (two inputs, two outputs, default routes, two bytes per
// sample). The frame store itself is not cleared; every entry whose data
// reaches the output is written in the same frame. Configuration must be
// written over the APB port only while the block is idle; the block itself
// does not enforce this.
module audio_channel_router #(
	parameter int MAX_CHANNELS = acr_pkg::DEF_MAX_CHANNELS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [acr_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [acr_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [acr_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	input  logic [acr_pkg::SAMPLE_W-1:0]      sample_in,
	input  logic                              in_valid,
	output logic                              in_ready,
	output logic [acr_pkg::SAMPLE_W-1:0]      sample_out,
	output logic [acr_pkg::CHAN_W-1:0]        out_channel,
	output logic                              frame_end,
	output logic                              out_valid,
	input  logic                              out_ready
);

	import acr_pkg::*;

	// The usable channel count is bounded by both the parameter and the
	// depth of the frame store (STORE_DEPTH).
	localparam int CHAN_LIMIT = (MAX_CHANNELS < STORE_DEPTH) ? MAX_CHANNELS : STORE_DEPTH;
	localparam int ADDR_W     = $clog2(CHAN_LIMIT);
	localparam logic [COUNT_W-1:0] LIMIT_C = COUNT_W'(CHAN_LIMIT);

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_RESOLVE = 5'b00010,
		ST_READ    = 5'b00100,
		ST_LOAD    = 5'b01000,
		ST_HOLD    = 5'b10000
	} state_t;

	cfg_t               cfg;
	route_t             route;
	state_t             state_q;
	logic [CHAN_W-1:0]  pos_q;
	logic [CHAN_W-1:0]  pair_q;
	logic [CHAN_W-1:0]  chan_q;
	logic               valid_q;
	logic [PAIR_SLOTS-1:0] hit_q;
	logic [CHAN_W-1:0]  src_tab_q [PAIR_SLOTS];
	logic               out_valid_q;
	logic [SAMPLE_W-1:0] sample_out_q;
	logic [CHAN_W-1:0]  out_channel_q;
	logic               frame_end_q;

	logic [COUNT_W-1:0] nin;
	logic [COUNT_W-1:0] nout;
	logic [COUNT_W-1:0] nr;
	logic               range_ok;
	logic               in_acc;
	logic               out_acc;
	logic [SAMPLE_W-1:0] ram_rdata;

	acr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	assign nin  = eff_count(cfg.in_channels, LIMIT_C);
	assign nout = eff_count(cfg.out_channels, LIMIT_C);

	// Number of route pairs in play for this frame. Default routes send a
	// mono input to the first two outputs, otherwise channel i to channel i.
	always_comb begin
		if (cfg.explicit_routing) begin
			nr = cfg.route_count;
		end else if (nin == COUNT_W'(1)) begin
			nr = (nout < COUNT_W'(2)) ? nout : COUNT_W'(2);
		end else begin
			nr = (nout < nin) ? nout : nin;
		end
	end

	assign range_ok = (nr != '0) && (nr <= LIMIT_C);

	// The shared compare unit: decodes one route pair and checks it against
	// the channel counts.
	acr_route u_route (
		.cfg      (cfg),
		.nin      (nin),
		.nout     (nout),
		.pair_idx (pair_q),
		.route    (route)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid & in_ready;
	assign out_acc  = out_valid_q & out_ready;

	// Frame store: written at the channel position on each input request,
	// read at the resolved source of the current output channel.
	acr_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (CHAN_LIMIT)
	) u_store (
		.clk   (clk),
		.we    (in_acc),
		.waddr (pos_q[ADDR_W-1:0]),
		.wdata (sample_in),
		.raddr (src_tab_q[chan_q][ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			pair_q      <= '0;
			chan_q      <= '0;
			valid_q     <= 1'b0;
			hit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (({1'b0, pos_q} + COUNT_W'(1)) < nin) begin
							pos_q <= pos_q + CHAN_W'(1);
						end else begin
							pos_q   <= '0;
							pair_q  <= '0;
							chan_q  <= '0;
							valid_q <= range_ok;
							hit_q   <= '0;
							state_q <= ST_RESOLVE;
						end
					end
				end
				ST_RESOLVE: begin
					if (!range_ok) begin
						state_q <= ST_READ;
					end else begin
						if (route.bad) begin
							valid_q <= 1'b0;
						end
						hit_q[route.tgt] <= 1'b1;
						if ({1'b0, pair_q} == (nr - COUNT_W'(1))) begin
							state_q <= ST_READ;
						end else begin
							pair_q <= pair_q + CHAN_W'(1);
						end
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						if (frame_end_q) begin
							state_q <= ST_IDLE;
						end else begin
							chan_q  <= chan_q + CHAN_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Route table and output register. A later pair with the same target
	// overwrites an earlier one, so the last matching pair wins.
	always_ff @(posedge clk) begin
		if ((state_q == ST_RESOLVE) && range_ok) begin
			src_tab_q[route.tgt] <= route.src;
		end
		if (state_q == ST_LOAD) begin
			sample_out_q  <= (valid_q && bps_ok(cfg.bytes_per_sample) && hit_q[chan_q])
				? (ram_rdata & bps_mask(cfg.bytes_per_sample)) : '0;
			out_channel_q <= chan_q;
			frame_end_q   <= (({1'b0, chan_q} + COUNT_W'(1)) == nout);
		end
	end

	assign sample_out  = sample_out_q;
	assign out_channel = out_channel_q;
	assign frame_end   = frame_end_q;
	assign out_valid   = out_valid_q;

endmodule
